// ----- rtl/core/segalloc_pkg.sv -----
// Shared types and constants for the segment allocator core.
// Used by segalloc_ctrl, segalloc_dpath and segment_allocator_first_best_fit_core.
`default_nettype none

package segalloc_pkg;

   // Width of a segment start address; lengths carry one more bit
   localparam int unsigned ADDRESS_BITS = 16;

   // Request and response payloads
   typedef struct packed {
      logic                    kind;
      logic [ADDRESS_BITS:0]   request_size;
      logic [ADDRESS_BITS-1:0] request_address;
   } req_type;

   typedef struct packed {
      logic [1:0]              status;
      logic [ADDRESS_BITS-1:0] granted_address;
   } rsp_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_FIT     = 2'd1,
      STATUS_NO_MATCH   = 2'd2,
      STATUS_TABLE_FULL = 2'd3
   } status_type;

   localparam logic KIND_ALLOCATE = 1'b0;
   localparam logic KIND_FREE     = 1'b1;

   // Configuration register map
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FIT_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOTAL_MEMORY = 2'd1;
   localparam int unsigned CSR_DATA_BITS = ADDRESS_BITS + 1;
   localparam logic [ADDRESS_BITS:0] TOTAL_RESET = 17'd65536;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_SHIFT,
      ST_WRITE_LO,
      ST_WRITE_HI,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic init;
      logic load;
      logic scan;
      logic decide;
      logic shift;
      logic write_lo;
      logic write_hi;
      logic respond;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;
      logic shift_done;
      logic need_hi;
      logic rsp_busy;
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/core/segment_allocator_first_best_fit_core.sv -----
// Top level of the segment allocator core: controller plus datapath.
// Depends on segalloc_pkg, segalloc_ctrl and segalloc_dpath.
`default_nettype none

// Segment allocator with first-fit or best-fit placement and coalescing of
// freed neighbors. The managed range is kept as an address-ordered table of
// segments (start, length, free flag) in a single-port-write memory of
// MAX_SEGMENTS entries. One request is handled at a time. An allocate or free
// takes one table read per live segment in the scan, a decision step, a shift
// of the entries above the touched segment (one entry per cycle, each written
// back after its read; none for an exact fit or an unmerged free), and one or
// two table writes, then the response transfer; the pace is set by the one
// read and one write port of the table. The response sits in an output
// register, so the next request is taken while it waits. Failed requests
// (no_fit, no_match, table_full) leave the table untouched and return
// address zero. Writing total_memory re-creates the table as a single free
// segment in the same cycle; after reset the block seeds that segment in its
// init state before it takes a request. Configuration writes are always
// taken and must only be issued while no request is in flight.

module segment_allocator_first_best_fit_core #(
   parameter int unsigned MAX_SEGMENTS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire segalloc_pkg::req_type req_data,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output segalloc_pkg::rsp_type      rsp_data,
   // configuration write channel
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [segalloc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [segalloc_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   segalloc_pkg::cmd_type  cmd;
   segalloc_pkg::stat_type stat;

   // Configuration transfers complete in the cycle they are offered.
   assign csr_ready = 1'b1;

   segalloc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   segalloc_dpath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/segalloc_ctrl.sv -----
// Sequencer for the segment allocator: scan, decide, table shift, writes, response.
// Depends on segalloc_pkg.
`default_nettype none

module segalloc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire segalloc_pkg::stat_type stat,
   output segalloc_pkg::cmd_type    cmd
);

   segalloc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= segalloc_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         segalloc_pkg::ST_INIT: begin
            cmd.init = 1'b1;
            state_in = segalloc_pkg::ST_IDLE;
         end
         segalloc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = segalloc_pkg::ST_SCAN;
            end
         end
         segalloc_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = segalloc_pkg::ST_DECIDE;
            end
         end
         segalloc_pkg::ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = segalloc_pkg::ST_SHIFT;
         end
         segalloc_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               state_in = segalloc_pkg::ST_WRITE_LO;
            end
         end
         segalloc_pkg::ST_WRITE_LO: begin
            cmd.write_lo = 1'b1;
            state_in = stat.need_hi ? segalloc_pkg::ST_WRITE_HI : segalloc_pkg::ST_DONE;
         end
         segalloc_pkg::ST_WRITE_HI: begin
            cmd.write_hi = 1'b1;
            state_in     = segalloc_pkg::ST_DONE;
         end
         segalloc_pkg::ST_DONE: begin
            if (!stat.rsp_busy) begin
               cmd.respond = 1'b1;
               state_in    = segalloc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = segalloc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/core/segalloc_dpath.sv -----
// Datapath of the segment allocator: segment table memory, scan and pick logic,
// table shift engine, configuration registers and response register. Depends on segalloc_pkg.
`default_nettype none

module segalloc_dpath #(
   parameter int unsigned MAX_SEGMENTS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire segalloc_pkg::cmd_type  cmd,
   output segalloc_pkg::stat_type      stat,
   input  wire segalloc_pkg::req_type  req_data,
   input  wire logic                   csr_valid,
   input  wire logic [segalloc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [segalloc_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output segalloc_pkg::rsp_type       rsp_data
);

   localparam int unsigned AB   = segalloc_pkg::ADDRESS_BITS;
   localparam int unsigned LW   = AB + 1;
   localparam int unsigned IW   = $clog2(MAX_SEGMENTS);
   localparam int unsigned CW   = $clog2(MAX_SEGMENTS + 1);
   localparam int unsigned CMPW = (LW > 17) ? LW : 17;
   localparam logic [LW-1:0] RANGE = {1'b1, {AB{1'b0}}};
   localparam logic [LW-1:0] TOTAL_INIT = segalloc_pkg::TOTAL_RESET;
   localparam logic [CW-1:0] COUNT_MAX  = CW'(MAX_SEGMENTS);

   // Segment table
   logic [AB-1:0] start_mem [MAX_SEGMENTS];
   logic [LW-1:0] len_mem   [MAX_SEGMENTS];
   logic          free_mem  [MAX_SEGMENTS];

   logic [IW-1:0] ra;
   logic [AB-1:0] rd_start;
   logic [LW-1:0] rd_len;
   logic          rd_free;

   logic          we;
   logic [IW-1:0] wa;
   logic [AB-1:0] wd_start;
   logic [LW-1:0] wd_len;
   logic          wd_free;

   always_ff @(posedge clock) begin
      if (we) begin
         start_mem[wa] <= wd_start;
         len_mem[wa]   <= wd_len;
         free_mem[wa]  <= wd_free;
      end
      rd_start <= start_mem[ra];
      rd_len   <= len_mem[ra];
      rd_free  <= free_mem[ra];
   end

   // Configuration and table size
   logic          fit_mode_ff;
   logic [LW-1:0] total_ff;
   logic [CW-1:0] count_ff;
   logic [LW-1:0] total_clamped;
   logic          csr_total_wr;

   always_comb begin
      if (CMPW'(csr_data) == '0) begin
         total_clamped = LW'(1);
      end else if (CMPW'(csr_data) > CMPW'(RANGE)) begin
         total_clamped = RANGE;
      end else begin
         total_clamped = LW'(csr_data);
      end
   end

   assign csr_total_wr = csr_valid && (csr_index == segalloc_pkg::CSR_TOTAL_MEMORY);

   // Request and scan state
   logic                            kind_ff;
   logic [segalloc_pkg::CSR_DATA_BITS-1:0] size_ff;
   logic [AB-1:0]                   addr_ff;
   logic [CW-1:0]                   scan_ff;
   logic                            ev_valid_ff;
   logic [IW-1:0]                   ev_idx_ff;
   logic                            found_ff;
   logic [IW-1:0]                   pick_ff;
   logic [AB-1:0]                   pick_start_ff;
   logic [LW-1:0]                   best_ff;
   logic                            last_free_ff;
   logic [AB-1:0]                   last_start_ff;
   logic [LW-1:0]                   last_len_ff;
   logic                            prev_free_ff;
   logic [AB-1:0]                   prev_start_ff;
   logic [LW-1:0]                   prev_len_ff;
   logic                            next_free_ff;
   logic [LW-1:0]                   next_len_ff;

   logic fits, take_a, match, take, next_hit;

   always_comb begin
      fits   = rd_free && (CMPW'(rd_len) >= CMPW'(size_ff));
      take_a = fits && (!found_ff || (fit_mode_ff && (rd_len < best_ff)));
      match  = !rd_free && (CMPW'(rd_start) == CMPW'(addr_ff))
               && (CMPW'(rd_len) == CMPW'(size_ff));
      take   = (kind_ff == segalloc_pkg::KIND_FREE) ? (match && !found_ff) : take_a;
      next_hit = found_ff && (CW'(ev_idx_ff) == (CW'(pick_ff) + CW'(1)));
   end

   // Decision
   logic [LW-1:0] size_l;
   logic          exact, alloc_ok, dec_ok, dec_need_hi;
   logic [1:0]    dec_status;
   logic [CW-1:0] merge_cnt, w_idx, src_first, dec_cnt, dec_src, dec_count;
   logic          dec_up;
   logic [AB-1:0] lo_start;
   logic [LW-1:0] lo_len;
   logic          lo_free;
   logic [IW-1:0] lo_addr;

   always_comb begin
      size_l    = LW'(size_ff);
      exact     = (best_ff == size_l);
      merge_cnt = CW'(prev_free_ff) + CW'(next_free_ff);
      w_idx     = prev_free_ff ? (CW'(pick_ff) - CW'(1)) : CW'(pick_ff);
      src_first = w_idx + CW'(1) + merge_cnt;
      alloc_ok  = 1'b0;
      dec_ok    = 1'b0;
      dec_need_hi = 1'b0;
      dec_up    = 1'b0;
      dec_cnt   = '0;
      dec_src   = '0;
      dec_count = count_ff;
      dec_status = segalloc_pkg::STATUS_OK;
      lo_addr   = pick_ff;
      lo_start  = pick_start_ff;
      lo_len    = size_l;
      lo_free   = 1'b0;
      if (kind_ff == segalloc_pkg::KIND_ALLOCATE) begin
         if ((size_ff == '0) || !found_ff) begin
            dec_status = segalloc_pkg::STATUS_NO_FIT;
         end else if (!exact && (count_ff >= COUNT_MAX)) begin
            dec_status = segalloc_pkg::STATUS_TABLE_FULL;
         end else begin
            alloc_ok = 1'b1;
            dec_ok   = 1'b1;
            if (!exact) begin
               // split: open a slot above the pick
               dec_need_hi = 1'b1;
               dec_up    = 1'b1;
               dec_src   = count_ff - CW'(1);
               dec_cnt   = count_ff - CW'(1) - CW'(pick_ff);
               dec_count = count_ff + CW'(1);
            end
         end
      end else begin
         if (!found_ff) begin
            dec_status = segalloc_pkg::STATUS_NO_MATCH;
         end else begin
            dec_ok    = 1'b1;
            lo_addr   = w_idx[IW-1:0];
            lo_start  = prev_free_ff ? prev_start_ff : pick_start_ff;
            lo_len    = (prev_free_ff ? prev_len_ff : '0) + best_ff
                        + (next_free_ff ? next_len_ff : '0);
            lo_free   = 1'b1;
            dec_src   = src_first;
            // without a merge the entries above stay where they are
            dec_cnt   = (merge_cnt == '0) ? '0 : (count_ff - src_first);
            dec_count = count_ff - merge_cnt;
         end
      end
   end

   // Update and shift registers
   logic          upd_ff, need_hi_ff, up_ff;
   logic [CW-1:0] merge_cnt_ff, src_ff, cnt_ff;
   logic          pend_ff;
   logic [IW-1:0] pend_addr_ff;
   logic [IW-1:0] lo_addr_ff, hi_addr_ff;
   logic [AB-1:0] lo_start_ff, hi_start_ff;
   logic [LW-1:0] lo_len_ff, hi_len_ff;
   logic          lo_free_ff;
   logic [1:0]    status_ff;
   logic [AB-1:0] granted_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [AB-1:0] rsp_granted_ff;
   logic [CW-1:0] pend_target;

   assign pend_target = up_ff ? (src_ff + CW'(1)) : (src_ff - merge_cnt_ff);

   always_comb begin
      ra = cmd.shift ? src_ff[IW-1:0] : scan_ff[IW-1:0];
   end

   // Single write port: configuration first, then init, shift, final writes
   always_comb begin
      we       = 1'b0;
      wa       = '0;
      wd_start = '0;
      wd_len   = total_ff;
      wd_free  = 1'b1;
      priority if (csr_total_wr) begin
         we     = 1'b1;
         wd_len = total_clamped;
      end else if (cmd.init) begin
         we = 1'b1;
      end else if (pend_ff) begin
         we       = 1'b1;
         wa       = pend_addr_ff;
         wd_start = rd_start;
         wd_len   = rd_len;
         wd_free  = rd_free;
      end else if (cmd.write_lo && upd_ff) begin
         we       = 1'b1;
         wa       = lo_addr_ff;
         wd_start = lo_start_ff;
         wd_len   = lo_len_ff;
         wd_free  = lo_free_ff;
      end else if (cmd.write_hi && need_hi_ff) begin
         we       = 1'b1;
         wa       = hi_addr_ff;
         wd_start = hi_start_ff;
         wd_len   = hi_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= 1'b0;
         total_ff     <= TOTAL_INIT;
         count_ff     <= CW'(1);
         ev_valid_ff  <= 1'b0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         upd_ff       <= 1'b0;
         need_hi_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == segalloc_pkg::CSR_FIT_MODE)) begin
            fit_mode_ff <= csr_data[0];
         end
         if (csr_total_wr) begin
            total_ff <= total_clamped;
         end
         if (csr_total_wr || cmd.init) begin
            count_ff <= CW'(1);
         end else if (cmd.decide && dec_ok) begin
            count_ff <= dec_count;
         end

         // scan pipeline: issue one read per cycle, evaluate it in the following cycle
         if (cmd.load) begin
            ev_valid_ff <= 1'b0;
         end else if (cmd.scan) begin
            ev_valid_ff <= (scan_ff < count_ff);
         end

         if (cmd.decide) begin
            upd_ff     <= dec_ok;
            need_hi_ff <= dec_need_hi;
            cnt_ff     <= dec_cnt;
         end else if (cmd.shift && (cnt_ff != '0)) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         pend_ff <= cmd.shift && (cnt_ff != '0);

         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff      <= req_data.kind;
         size_ff      <= req_data.request_size;
         addr_ff      <= req_data.request_address;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         prev_free_ff <= 1'b0;
         next_free_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (scan_ff < count_ff) begin
            scan_ff   <= scan_ff + CW'(1);
            ev_idx_ff <= scan_ff[IW-1:0];
         end
         if (ev_valid_ff) begin
            if (take) begin
               found_ff      <= 1'b1;
               pick_ff       <= ev_idx_ff;
               pick_start_ff <= rd_start;
               best_ff       <= rd_len;
               prev_free_ff  <= (ev_idx_ff != '0) && last_free_ff;
               prev_start_ff <= last_start_ff;
               prev_len_ff   <= last_len_ff;
            end
            if (next_hit) begin
               next_free_ff <= rd_free;
               next_len_ff  <= rd_len;
            end
            last_free_ff  <= rd_free;
            last_start_ff <= rd_start;
            last_len_ff   <= rd_len;
         end
      end

      if (cmd.decide) begin
         up_ff        <= dec_up;
         merge_cnt_ff <= merge_cnt;
         src_ff       <= dec_src;
         lo_addr_ff   <= lo_addr;
         lo_start_ff  <= lo_start;
         lo_len_ff    <= lo_len;
         lo_free_ff   <= lo_free;
         hi_addr_ff   <= IW'(CW'(pick_ff) + CW'(1));
         hi_start_ff  <= pick_start_ff + AB'(size_ff);
         hi_len_ff    <= best_ff - size_l;
         status_ff    <= dec_status;
         granted_ff   <= alloc_ok ? pick_start_ff : '0;
      end else if (cmd.shift && (cnt_ff != '0)) begin
         src_ff       <= up_ff ? (src_ff - CW'(1)) : (src_ff + CW'(1));
         pend_addr_ff <= pend_target[IW-1:0];
      end

      // hold the offered response steady while the next request runs
      if (cmd.respond) begin
         rsp_status_ff  <= status_ff;
         rsp_granted_ff <= granted_ff;
      end
   end

   always_comb begin
      stat.scan_done  = (scan_ff >= count_ff) && !ev_valid_ff;
      stat.shift_done = (cnt_ff == '0) && !pend_ff;
      stat.need_hi    = need_hi_ff;
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_data.status          = rsp_status_ff;
   assign rsp_data.granted_address = rsp_granted_ff;

endmodule

`default_nettype wire
